FILE: design/hid_mouse_report_to_packet_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the mouse report converter
// Shared property wrappers used by the converter's internal checks.
// ----------------------------------------------------------------------------
`ifndef HID_MOUSE_REPORT_TO_PACKET_MACROS_SVH
`define HID_MOUSE_REPORT_TO_PACKET_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HMR_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hmr check failed: same-cycle property");

// The consequent must hold in the cycle after the antecedent.
`define HMR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hmr check failed: next-cycle property");

`endif

FILE: design/hmr_pkg.sv
// ----------------------------------------------------------------------------
// hmr_pkg
// Types, codes and sizes shared by the mouse report converter modules.
// ----------------------------------------------------------------------------
package hmr_pkg;

   localparam int REPORT_BYTES  = 8;
   localparam int LEN_W         = 4;
   localparam int WHEEL_REPEAT  = 3;
   localparam int WHEEL_STEPS   = 2 * WHEEL_REPEAT;
   localparam int WHEEL_CNT_W   = $clog2(WHEEL_STEPS + 1);
   localparam int QUEUE_DEPTH   = 2;
   localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

   localparam logic [LEN_W-1:0] LEN_MIN       = 4'd3;
   localparam logic [LEN_W-1:0] LEN_MAX       = 4'd8;
   localparam logic [LEN_W-1:0] ID_LEN_MIN    = 4'd6;
   localparam logic [LEN_W-1:0] WHEEL_LEN_MIN = 4'd4;

   localparam logic [7:0] REPORT_ID_MOUSE = 8'h01;
   localparam logic [7:0] HDR_BASE        = 8'hF8;
   localparam logic [7:0] KEY_ENTER_MAKE  = 8'h72;
   localparam logic [7:0] KEY_ENTER_BREAK = 8'hF2;
   localparam logic [7:0] KEY_UP_MAKE     = 8'h48;
   localparam logic [7:0] KEY_UP_BREAK    = 8'hC8;
   localparam logic [7:0] KEY_DOWN_MAKE   = 8'h50;
   localparam logic [7:0] KEY_DOWN_BREAK  = 8'hD0;

   localparam logic KIND_KEY   = 1'b0;
   localparam logic KIND_MOUSE = 1'b1;

   localparam logic CSR_KEY_ENABLE   = 1'b0;
   localparam logic CSR_MOUSE_ENABLE = 1'b1;

   typedef struct packed {
      logic       xfer_error;
      logic [3:0] report_len;
      logic [7:0] report_byte_0;
      logic [7:0] report_byte_1;
      logic [7:0] report_byte_2;
      logic [7:0] report_byte_3;
      logic [7:0] report_byte_4;
      logic [7:0] report_byte_5;
      logic [7:0] report_byte_6;
      logic [7:0] report_byte_7;
   } req_payload_type;

   typedef struct packed {
      logic              out_kind;
      logic [7:0]        key_code;
      logic [7:0]        packet_header;
      logic signed [7:0] delta_x;
      logic signed [7:0] delta_y;
      logic              last_out;
   } rsp_payload_type;

   // One classified report as handed from the front end to the emitter.
   typedef struct packed {
      logic       mid_press;
      logic       wheel_move;
      logic       wheel_up;
      logic       mouse;
      logic [7:0] header;
      logic [7:0] dx;
      logic [7:0] dy;
   } cmd_type;

endpackage

FILE: design/hmr_front.sv
// ----------------------------------------------------------------------------
// hmr_front
// Accepts reports, filters errors and repeats, and classifies each report
// into a command for the emitter.
// ----------------------------------------------------------------------------
module hmr_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  hmr_pkg::req_payload_type req_payload,
   input  logic                     key_enable,
   input  logic                     mouse_enable,
   input  logic                     queue_full,
   output logic                     push,
   output hmr_pkg::cmd_type         push_data
);
   import hmr_pkg::*;

   logic [7:0]       prev_ff [REPORT_BYTES];
   logic [7:0]       prev_in [REPORT_BYTES];
   logic [7:0]       bytes   [REPORT_BYTES];
   logic [LEN_W-1:0] len;
   logic             take;
   logic             len_ok;
   logic             changed;
   logic             id_layout;
   logic             good_report;
   logic [7:0]       buttons;
   logic [7:0]       prior_buttons;
   logic [7:0]       wheel;

   assign req_stall = queue_full;
   assign take      = req_valid && !req_stall;
   assign len       = req_payload.report_len;

   always_comb begin
      bytes[0] = req_payload.report_byte_0;
      bytes[1] = req_payload.report_byte_1;
      bytes[2] = req_payload.report_byte_2;
      bytes[3] = req_payload.report_byte_3;
      bytes[4] = req_payload.report_byte_4;
      bytes[5] = req_payload.report_byte_5;
      bytes[6] = req_payload.report_byte_6;
      bytes[7] = req_payload.report_byte_7;

      len_ok = !req_payload.xfer_error && (len >= LEN_MIN) && (len <= LEN_MAX);

      changed = 1'b0;
      for (int i = 0; i < REPORT_BYTES; i++) begin
         if ((LEN_W'(i) < len) && (bytes[i] != prev_ff[i])) begin
            changed = 1'b1;
         end
      end

      id_layout = (len >= ID_LEN_MIN) && (bytes[0] == REPORT_ID_MOUSE);
      if (id_layout) begin
         buttons       = bytes[1];
         prior_buttons = prev_ff[1];
         push_data.dx  = bytes[2];
         push_data.dy  = bytes[3];
         wheel         = bytes[4];
      end else begin
         buttons       = bytes[0];
         prior_buttons = prev_ff[0];
         push_data.dx  = bytes[1];
         push_data.dy  = bytes[2];
         wheel         = (len >= WHEEL_LEN_MIN) ? bytes[3] : 8'd0;
      end

      push_data.mid_press  = key_enable && buttons[2] && !prior_buttons[2];
      push_data.wheel_move = key_enable && (wheel != 8'd0);
      push_data.wheel_up   = !wheel[7];
      push_data.mouse      = mouse_enable;
      // Left and right trade places in the packet header.
      push_data.header     = HDR_BASE | {6'd0, buttons[0], buttons[1]};

      good_report = take && len_ok && changed;
      push = good_report &&
             (push_data.mid_press || push_data.wheel_move || push_data.mouse);

      for (int i = 0; i < REPORT_BYTES; i++) begin
         prev_in[i] = (good_report && (LEN_W'(i) < len)) ? bytes[i] : prev_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < REPORT_BYTES; i++) begin
            prev_ff[i] <= 8'd0;
         end
      end else begin
         prev_ff <= prev_in;
      end
   end

endmodule

FILE: design/hmr_queue.sv
// ----------------------------------------------------------------------------
// hmr_queue
// Short command queue between the front end and the emitter.
// ----------------------------------------------------------------------------
`include "hid_mouse_report_to_packet_macros.svh"

module hmr_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  hmr_pkg::cmd_type push_data,
   output logic             full,
   input  logic             pop,
   output hmr_pkg::cmd_type pop_data,
   output logic             not_empty
);
   import hmr_pkg::*;

   cmd_type             slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   assign full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   `HMR_ASSERT_SAME(a_no_push_when_full, clock, reset, push, !full)
   `HMR_ASSERT_SAME(a_no_pop_when_empty, clock, reset, pop, not_empty)
   `HMR_ASSERT_SAME(a_count_in_range, clock, reset, 1'b1, count_ff <= QCNT_W'(QUEUE_DEPTH))

endmodule

FILE: design/hmr_back.sv
// ----------------------------------------------------------------------------
// hmr_back
// Emitter: walks one command at a time, producing key codes and the mouse
// packet into the result register, one result per cycle while not stalled.
// ----------------------------------------------------------------------------
`include "hid_mouse_report_to_packet_macros.svh"

module hmr_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     cmd_available,
   input  hmr_pkg::cmd_type         cmd_data,
   output logic                     pop,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output hmr_pkg::rsp_payload_type rsp_payload
);
   import hmr_pkg::*;

   cmd_type                cur_ff;
   logic                   cur_valid_ff, cur_valid_in;
   logic [1:0]             mid_left_ff, mid_left_in, mid_next;
   logic [WHEEL_CNT_W-1:0] wheel_left_ff, wheel_left_in, wheel_next;
   logic                   mouse_left_ff, mouse_left_in, mouse_next;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_payload_type        rsp_ff, rsp_in;
   rsp_payload_type        result;
   logic                   advance;
   logic                   emit;
   logic                   last;
   logic                   cmd_has_work;
   logic                   key_rsp;
   logic                   key_rsp_clean;

   assign advance     = !rsp_valid_ff || !rsp_stall;
   assign emit        = advance && cur_valid_ff;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assign cmd_has_work  = (mid_left_ff != 2'd0) || (wheel_left_ff != '0) || mouse_left_ff;
   assign key_rsp       = rsp_valid_ff && (rsp_ff.out_kind == KIND_KEY);
   assign key_rsp_clean = (rsp_ff.packet_header == 8'd0) && (rsp_ff.key_code != 8'd0);

   // Pick the next result: middle-button pair first, then wheel pairs,
   // then the mouse packet.
   always_comb begin
      mid_next   = mid_left_ff;
      wheel_next = wheel_left_ff;
      mouse_next = mouse_left_ff;
      result     = '0;
      if (mid_left_ff != 2'd0) begin
         result.out_kind = KIND_KEY;
         result.key_code = (mid_left_ff == 2'd2) ? KEY_ENTER_MAKE : KEY_ENTER_BREAK;
         mid_next        = mid_left_ff - 1'b1;
      end else if (wheel_left_ff != '0) begin
         result.out_kind = KIND_KEY;
         // The count starts even, so even counts are makes and odd are breaks.
         if (!wheel_left_ff[0]) begin
            result.key_code = cur_ff.wheel_up ? KEY_UP_MAKE : KEY_DOWN_MAKE;
         end else begin
            result.key_code = cur_ff.wheel_up ? KEY_UP_BREAK : KEY_DOWN_BREAK;
         end
         wheel_next = wheel_left_ff - 1'b1;
      end else begin
         result.out_kind      = KIND_MOUSE;
         result.packet_header = cur_ff.header;
         result.delta_x       = cur_ff.dx;
         result.delta_y       = cur_ff.dy;
         mouse_next           = 1'b0;
      end
      last            = (mid_next == 2'd0) && (wheel_next == '0) && !mouse_next;
      result.last_out = last;
   end

   always_comb begin
      pop           = cmd_available && (!cur_valid_ff || (emit && last));
      cur_valid_in  = cur_valid_ff;
      mid_left_in   = mid_left_ff;
      wheel_left_in = wheel_left_ff;
      mouse_left_in = mouse_left_ff;
      if (emit) begin
         mid_left_in   = mid_next;
         wheel_left_in = wheel_next;
         mouse_left_in = mouse_next;
         if (last) begin
            cur_valid_in = 1'b0;
         end
      end
      if (pop) begin
         cur_valid_in  = 1'b1;
         mid_left_in   = cmd_data.mid_press ? 2'd2 : 2'd0;
         wheel_left_in = cmd_data.wheel_move ? WHEEL_CNT_W'(WHEEL_STEPS) : '0;
         mouse_left_in = cmd_data.mouse;
      end

      rsp_in = rsp_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_in       = result;
      end else if (advance) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff  <= 1'b0;
         mid_left_ff   <= 2'd0;
         wheel_left_ff <= '0;
         mouse_left_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         cur_valid_ff  <= cur_valid_in;
         mid_left_ff   <= mid_left_in;
         wheel_left_ff <= wheel_left_in;
         mouse_left_ff <= mouse_left_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         cur_ff <= cmd_data;
      end
      rsp_ff <= rsp_in;
   end

   `HMR_ASSERT_NEXT(a_cmd_held_until_last, clock, reset, emit && !last, cur_valid_ff)
   `HMR_ASSERT_SAME(a_active_cmd_has_work, clock, reset, cur_valid_ff, cmd_has_work)
   `HMR_ASSERT_SAME(a_key_result_clean, clock, reset, key_rsp, key_rsp_clean)

endmodule

FILE: design/hid_mouse_report_to_packet.sv
// Reports pass the queue and the command register, then the result register.
// Throughput: one result per cycle while not stalled; a report yields 1 to 9
// results (two middle-button codes, six wheel codes, one packet).
// A two-entry command queue lets reports be taken while results drain.
// Reset (synchronous, active high) clears the stored report to zeros,
// both enables to 0, and empties the queue and result register.
// ----------------------------------------------------------------------------
// hid_mouse_report_to_packet
// Converts mouse reports into key codes and three-byte relative packets.
// ----------------------------------------------------------------------------
module hid_mouse_report_to_packet (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  hmr_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output hmr_pkg::rsp_payload_type rsp_payload,
   input  logic                     csr_wr_en,
   input  logic                     csr_index,
   input  logic                     csr_wdata
);
   import hmr_pkg::*;

   logic    key_enable_ff, key_enable_in;
   logic    mouse_enable_ff, mouse_enable_in;
   logic    queue_full;
   logic    push;
   cmd_type push_data;
   logic    pop;
   cmd_type pop_data;
   logic    not_empty;

   always_comb begin
      key_enable_in   = key_enable_ff;
      mouse_enable_in = mouse_enable_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_KEY_ENABLE:   key_enable_in   = csr_wdata;
            CSR_MOUSE_ENABLE: mouse_enable_in = csr_wdata;
            default:          ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_enable_ff   <= 1'b0;
         mouse_enable_ff <= 1'b0;
      end else begin
         key_enable_ff   <= key_enable_in;
         mouse_enable_ff <= mouse_enable_in;
      end
   end

   hmr_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_payload  (req_payload),
      .key_enable   (key_enable_ff),
      .mouse_enable (mouse_enable_ff),
      .queue_full   (queue_full),
      .push         (push),
      .push_data    (push_data)
   );

   hmr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (pop),
      .pop_data  (pop_data),
      .not_empty (not_empty)
   );

   hmr_back u_back (
      .clock         (clock),
      .reset         (reset),
      .cmd_available (not_empty),
      .cmd_data      (pop_data),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_payload   (rsp_payload)
   );

endmodule

FILE: bench/hid_mouse_report_to_packet_tb.sv
// ----------------------------------------------------------------------------
// Mouse report converter testbench
// Sends USB mouse reports through the converter and checks every key code and
// relative packet against a cycle-free prediction of the conversion, under
// random and forced stalls on both sides and several enable settings.
// ----------------------------------------------------------------------------
module hid_mouse_report_to_packet_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import hmr_pkg::*;

   localparam int CYCLE_LIMIT     = 200000;
   localparam int SETTLE_CYCLES   = 12;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int MAX_SHOWN       = 10;
   localparam int MAX_PER_REPORT  = 3 + 2 * WHEEL_REPEAT;

   logic            clock       = 1'b0;
   logic            reset       = 1'b1;
   logic            req_valid   = 1'b0;
   logic            req_stall;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_stall   = 1'b0;
   rsp_payload_type rsp_payload;
   logic            csr_wr_en   = 1'b0;
   logic            csr_index   = 1'b0;
   logic            csr_wdata   = 1'b0;
   logic            hold_start  = 1'b0;

   // Predictor state: report bytes as converted reports left them, and the enables.
   logic [7:0]      stored_report [REPORT_BYTES];
   logic            key_on;
   logic            mouse_on;
   rsp_payload_type pending_results [$];
   req_payload_type last_sent = '0;

   int send_idle_pct;
   int rsp_idle_pct;
   int hold_left;
   int cycle_count;
   int mismatches;
   int reports_sent;
   int reports_converted;
   int key_codes_seen;
   int packets_seen;

   hid_mouse_report_to_packet i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout with %0d results still expected", pending_results.size());
         $display("TEST FAILED");
         $finish;
      end
   end

   // Long receiver hold-off, loaded by a one-cycle start pulse and counted
   // down here.
   always @(posedge clock) begin
      if (hold_start) begin
         hold_left <= HOLD_OFF_CYCLES;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   always @(posedge clock) begin
      rsp_stall <= (hold_left != 0) || ($urandom_range(99) < rsp_idle_pct);
   end

   function automatic string describe_result(rsp_payload_type r);
      return $sformatf("kind=%0d code=%h hdr=%h dx=%h dy=%h last=%0d",
                       r.out_kind, r.key_code, r.packet_header, r.delta_x, r.delta_y,
                       r.last_out);
   endfunction

   always @(posedge clock) begin : check_results
      rsp_payload_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (rsp_payload.out_kind == KIND_MOUSE) begin
            packets_seen++;
         end else begin
            key_codes_seen++;
         end
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_SHOWN) begin
               $display("cycle %0d: result with none expected: %s", cycle_count,
                        describe_result(rsp_payload));
            end
         end else begin
            want = pending_results.pop_front();
            if (rsp_payload.out_kind !== want.out_kind ||
                rsp_payload.key_code !== want.key_code ||
                rsp_payload.packet_header !== want.packet_header ||
                rsp_payload.delta_x !== want.delta_x ||
                rsp_payload.delta_y !== want.delta_y ||
                rsp_payload.last_out !== want.last_out) begin
               mismatches++;
               if (mismatches <= MAX_SHOWN) begin
                  $display("cycle %0d: expected %s", cycle_count, describe_result(want));
                  $display("cycle %0d: got      %s", cycle_count,
                           describe_result(rsp_payload));
               end
            end
         end
      end
   end

   function automatic rsp_payload_type key_result(logic [7:0] code);
      rsp_payload_type r;
      r = '0;
      r.out_kind = KIND_KEY;
      r.key_code = code;
      return r;
   endfunction

   // Works out the key codes and packet that one report turns into and
   // queues them; dropped and unchanged reports leave everything as it is.
   function automatic void convert_report(req_payload_type rpt);
      logic [7:0]      b [REPORT_BYTES];
      int              len;
      int              n;
      bit              changed;
      logic [7:0]      buttons;
      logic [7:0]      prior_buttons;
      logic [7:0]      dx;
      logic [7:0]      dy;
      logic [7:0]      wheel;
      rsp_payload_type outs [MAX_PER_REPORT];
      b = '{rpt.report_byte_0, rpt.report_byte_1, rpt.report_byte_2, rpt.report_byte_3,
            rpt.report_byte_4, rpt.report_byte_5, rpt.report_byte_6, rpt.report_byte_7};
      len = rpt.report_len;
      changed = 1'b0;
      n = 0;
      if (rpt.xfer_error || len < LEN_MIN || len > LEN_MAX) begin
         return;
      end
      for (int i = 0; i < len; i++) begin
         if (b[i] != stored_report[i]) begin
            changed = 1'b1;
         end
      end
      if (!changed) begin
         return;
      end
      if (len >= ID_LEN_MIN && b[0] == REPORT_ID_MOUSE) begin
         buttons       = b[1];
         prior_buttons = stored_report[1];
         dx            = b[2];
         dy            = b[3];
         wheel         = b[4];
      end else begin
         buttons       = b[0];
         prior_buttons = stored_report[0];
         dx            = b[1];
         dy            = b[2];
         wheel         = (len >= WHEEL_LEN_MIN) ? b[3] : 8'h00;
      end
      for (int i = 0; i < len; i++) begin
         stored_report[i] = b[i];
      end
      reports_converted++;

      if (key_on) begin
         if (buttons[2] && !prior_buttons[2]) begin
            outs[n] = key_result(KEY_ENTER_MAKE);
            outs[n + 1] = key_result(KEY_ENTER_BREAK);
            n += 2;
         end
         if (wheel != 8'h00) begin
            for (int k = 0; k < WHEEL_REPEAT; k++) begin
               outs[n] = key_result(wheel[7] ? KEY_DOWN_MAKE : KEY_UP_MAKE);
               outs[n + 1] = key_result(wheel[7] ? KEY_DOWN_BREAK : KEY_UP_BREAK);
               n += 2;
            end
         end
      end
      if (mouse_on) begin
         outs[n] = '0;
         outs[n].out_kind = KIND_MOUSE;
         // Left goes to bit 1 and right to bit 0 of the header.
         outs[n].packet_header = HDR_BASE | {6'b0, buttons[0], buttons[1]};
         outs[n].delta_x = dx;
         outs[n].delta_y = dy;
         n++;
      end
      if (n > 0) begin
         outs[n - 1].last_out = 1'b1;
      end
      for (int i = 0; i < n; i++) begin
         pending_results.push_back(outs[i]);
      end
   endfunction

   // Byte 0 of the report sits in the top byte of the bytes argument.
   function automatic req_payload_type make_report(bit err, logic [3:0] len,
                                                   logic [63:0] bytes);
      return {err, len, bytes};
   endfunction

   function automatic req_payload_type well_formed_report();
      logic [63:0] bytes;
      logic [3:0]  len;
      logic [7:0]  wheel;
      bytes = {$urandom, $urandom};
      len   = 4'($urandom_range(LEN_MAX, LEN_MIN));
      wheel = ($urandom_range(99) < 40) ? 8'h00 : 8'($urandom_range(255));
      if (len >= ID_LEN_MIN && $urandom_range(99) < 40) begin
         bytes[63:56] = REPORT_ID_MOUSE;
         bytes[31:24] = wheel;
      end else begin
         bytes[39:32] = wheel;
      end
      return make_report(1'b0, len, bytes);
   endfunction

   task automatic send_report(req_payload_type rpt);
      int gap;
      gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(4, 1) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= rpt;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      convert_report(rpt);
      last_sent = rpt;
      reports_sent++;
   endtask

   // Lets reports that cause no results clear the pipeline as well.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic index, logic value);
      wait_idle();
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (index == CSR_KEY_ENABLE) begin
         key_on = value;
      end else begin
         mouse_on = value;
      end
   endtask

   task automatic set_idling(int send_pct, int rsp_pct);
      send_idle_pct = send_pct;
      rsp_idle_pct <= rsp_pct;
   endtask

   // With both enables at their reset value nothing comes out, but the
   // stored report must still follow the input.
   task automatic test_disabled_outputs();
      send_report(make_report(1'b0, 4'd3, 64'h04_10_20_00_00_00_00_00));
      send_report(make_report(1'b0, 4'd8, 64'h04_10_20_00_00_00_00_AB));
      write_csr(CSR_KEY_ENABLE, 1'b1);
      write_csr(CSR_MOUSE_ENABLE, 1'b1);
   endtask

   task automatic test_boot_layout();
      // Middle still held from before, and a short report ignores byte 3.
      send_report(make_report(1'b0, 4'd3, 64'h04_05_06_33_00_00_00_00));
      send_report(make_report(1'b0, 4'd4, 64'h01_7F_80_01_00_00_00_00));
      send_report(make_report(1'b0, 4'd4, 64'h02_80_7F_FF_00_00_00_00));
      send_report(make_report(1'b0, 4'd4, 64'h07_00_00_80_00_00_00_00));
      send_report(make_report(1'b0, 4'd5, 64'h00_FF_01_00_AA_00_00_00));
      send_report(make_report(1'b0, 4'd8, 64'h05_01_FF_7F_00_00_00_00));
   endtask

   task automatic test_report_id_layout();
      send_report(make_report(1'b0, 4'd6, 64'h01_04_10_F0_FF_00_00_00));
      send_report(make_report(1'b0, 4'd8, 64'h01_03_80_7F_00_11_22_33));
      // Too short for a report ID, so byte 0 is read as buttons.
      send_report(make_report(1'b0, 4'd5, 64'h01_04_22_EE_01_00_00_00));
      send_report(make_report(1'b0, 4'd6, 64'h02_04_22_EE_01_00_00_00));
      send_report(make_report(1'b0, 4'd7, 64'h01_04_7F_80_C0_55_66_00));
   endtask

   task automatic test_dropped_reports();
      send_report(make_report(1'b1, 4'd6, 64'h04_11_22_33_44_55_66_77));
      send_report(make_report(1'b0, 4'd0, 64'h04_11_22_33_44_55_66_77));
      send_report(make_report(1'b0, 4'd1, 64'h04_11_22_33_44_55_66_77));
      send_report(make_report(1'b0, 4'd2, 64'h04_11_22_33_44_55_66_77));
      send_report(make_report(1'b0, 4'd9, 64'h04_11_22_33_44_55_66_77));
      send_report(make_report(1'b0, 4'd15, 64'hFF_FF_FF_FF_FF_FF_FF_FF));
      send_report(make_report(1'b0, 4'd7, 64'h01_04_7F_80_C0_55_66_00));
      // Same over its length; the differing bytes lie beyond it.
      send_report(make_report(1'b0, 4'd5, 64'h01_04_7F_80_C0_99_99_99));
      send_report(make_report(1'b0, 4'd7, 64'h01_04_7E_80_C0_55_66_00));
   endtask

   task automatic test_single_enables();
      write_csr(CSR_MOUSE_ENABLE, 1'b0);
      send_report(make_report(1'b0, 4'd4, 64'h04_10_10_01_00_00_00_00));
      write_csr(CSR_KEY_ENABLE, 1'b0);
      write_csr(CSR_MOUSE_ENABLE, 1'b1);
      send_report(make_report(1'b0, 4'd4, 64'h00_20_20_FF_00_00_00_00));
      send_report(make_report(1'b0, 4'd4, 64'h04_21_20_FF_00_00_00_00));
      write_csr(CSR_KEY_ENABLE, 1'b1);
   endtask

   // Mostly well-formed reports, mixed with failed transfers, bad lengths
   // and repeats of the previous report.
   task automatic test_random_reports(int send_pct, int rsp_pct, int count);
      req_payload_type rpt;
      logic [63:0]     bytes;
      int              pick;
      int              formed;
      formed = 0;
      set_idling(send_pct, rsp_pct);
      while (formed < count) begin
         pick  = $urandom_range(99);
         bytes = {$urandom, $urandom};
         if (pick < 8) begin
            rpt = make_report(1'b1, 4'($urandom_range(15)), bytes);
         end else if (pick < 14) begin
            rpt = make_report(1'b0, ($urandom_range(1) != 0) ? 4'($urandom_range(2, 0))
                                                              : 4'($urandom_range(15, 9)),
                              bytes);
         end else if (pick < 22) begin
            rpt = last_sent;
            if (pick < 18) begin
               if (rpt.report_len <= 5) rpt.report_byte_5 = bytes[7:0];
               if (rpt.report_len <= 6) rpt.report_byte_6 = bytes[15:8];
               if (rpt.report_len <= 7) rpt.report_byte_7 = bytes[23:16];
            end
         end else begin
            rpt = well_formed_report();
            formed++;
         end
         send_report(rpt);
      end
   endtask

   // The receiver stops for a long stretch while reports keep coming, so
   // the command queue fills and the input has to stall.
   task automatic test_receiver_hold_off();
      set_idling(0, 0);
      hold_start <= 1'b1;
      @(posedge clock);
      hold_start <= 1'b0;
      repeat (14) send_report(well_formed_report());
   endtask

   initial begin
      for (int i = 0; i < REPORT_BYTES; i++) begin
         stored_report[i] = 8'h00;
      end
      key_on   = 1'b0;
      mouse_on = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_disabled_outputs();
      test_boot_layout();
      test_report_id_layout();
      test_dropped_reports();
      test_single_enables();
      test_random_reports(26, 50, 21);
      test_random_reports(50, 26, 21);
      test_receiver_hold_off();
      test_random_reports(0, 0, 21);

      wait_idle();
      $display("%0d reports sent, %0d converted; %0d key codes and %0d packets checked",
               reports_sent, reports_converted, key_codes_seen, packets_seen);
      $display("covered both layouts, drops, enable settings, stalls and a long hold-off");
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

FILE: sim.f
+incdir+design
design/hmr_pkg.sv
design/hmr_front.sv
design/hmr_queue.sv
design/hmr_back.sv
design/hid_mouse_report_to_packet.sv
bench/hid_mouse_report_to_packet_tb.sv
